FILE: hdl/pqrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqrs_pkg
// Shared types, codes and fixed-point helpers of the PLS Q residual block.
// ----------------------------------------------------------------------------
package pqrs_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_LOAD_MEAN     = 2'd0;
    localparam logic [1:0] OP_LOAD_ROTATION = 2'd1;
    localparam logic [1:0] OP_LOAD_LOADING  = 2'd2;
    localparam logic [1:0] OP_SAMPLE        = 2'd3;

    // Configuration register indexes
    localparam logic [3:0] REG_FEATURE_COUNT   = 4'd0;
    localparam logic [3:0] REG_COMPONENT_COUNT = 4'd1;

    localparam logic [8:0] FEATURE_COUNT_RESET   = 9'd2;
    localparam logic [3:0] COMPONENT_COUNT_RESET = 4'd1;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [63:0]        Q_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         feature_index;
        logic [2:0]         component_index;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic [62:0] q_value;
        logic        saturated;
    } result_t;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic [8:0] feature_count;
        logic [3:0] component_count;
    } cfg_regs_t;

    // Head of the queue between front and back
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] sum;
    } sat64_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sat32_t;

    // Saturating signed 64-bit add
    function automatic sat64_t sat_add64(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
        sat64_t             r;
        logic signed [63:0] s;
        s     = a + b;
        r.sat = (a[63] == b[63]) && (s[63] != a[63]);
        r.sum = r.sat ? (a[63] ? S64_MIN : S64_MAX) : s;
        return r;
    endfunction

    // Saturate a 33-bit signed value to 32 bits
    function automatic sat32_t sat32_from33(input logic signed [32:0] v);
        sat32_t r;
        r.sat = (v[32] != v[31]);
        r.val = r.sat ? (v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : v[31:0];
        return r;
    endfunction

    // Q32.32 to Q16.16, round half up, saturated to 32 bits
    function automatic sat32_t round_q16(input logic signed [63:0] v);
        sat32_t             r;
        logic signed [63:0] k;
        logic signed [63:0] h;
        k = v >>> 15;
        h = (k + 64'sd1) >>> 1;
        if (h > 64'sd2147483647)
        begin
            r.sat = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end
        else if (h < -64'sd2147483648)
        begin
            r.sat = 1'b1;
            r.val = 32'sh8000_0000;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = h[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/pqrs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqrs_if
// Valid/ready channels of the block: input items, results, config writes.
// ----------------------------------------------------------------------------
interface pqrs_item_if;
    logic           valid;
    logic           ready;
    pqrs_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pqrs_result_if;
    logic             valid;
    logic             ready;
    pqrs_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pqrs_cfg_if;
    logic                valid;
    logic                ready;
    pqrs_pkg::cfg_write_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pqrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqrs_front
// Accepts input transactions, drops out-of-range loads, and queues the rest
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pqrs_front #(
    parameter int FEATURES_MAX   = 256,
    parameter int COMPONENTS_MAX = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pqrs_item_if.sink             items,
    output pqrs_pkg::queue_head_t head,
    input  logic                  pop
);
    import pqrs_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       keep;
    logic       push;

    // Classify: samples always kept, loads only when addressing the tables
    assign keep = (items.data.operation == OP_SAMPLE) ||
                  ((int'(items.data.feature_index) < FEATURES_MAX) &&
                   (int'(items.data.component_index) < COMPONENTS_MAX));

    assign items.ready = (count_reg != 2'd2);
    assign push        = items.valid && items.ready && keep;

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Hold queued payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= items.data;
        end
    end

endmodule

FILE: hdl/pqrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqrs_back
// Executes queued transactions: table loads, per-sample centering and score
// accumulation, and the row reconstruction and residual sum, all on one
// shared multiplier.
// ----------------------------------------------------------------------------
module pqrs_back #(
    parameter int FEATURES_MAX   = 256,
    parameter int COMPONENTS_MAX = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pqrs_pkg::cfg_regs_t   cfg_regs,
    input  pqrs_pkg::queue_head_t head,
    output logic                  pop,
    pqrs_result_if.source         results
);
    import pqrs_pkg::*;

    localparam int FW  = $clog2(FEATURES_MAX);
    localparam int NW  = $clog2(FEATURES_MAX + 1);
    localparam int CW  = (COMPONENTS_MAX > 1) ? $clog2(COMPONENTS_MAX) : 1;
    localparam int CNW = (COMPONENTS_MAX > 1) ? $clog2(COMPONENTS_MAX + 1) : 1;
    localparam int AW  = (FEATURES_MAX * COMPONENTS_MAX > 1) ?
                         $clog2(FEATURES_MAX * COMPONENTS_MAX) : 1;
    localparam int TD  = FEATURES_MAX * COMPONENTS_MAX;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CEN  = 4'd1;
    localparam logic [3:0] ST_SRD  = 4'd2;
    localparam logic [3:0] ST_SMUL = 4'd3;
    localparam logic [3:0] ST_SACC = 4'd4;
    localparam logic [3:0] ST_RND  = 4'd5;
    localparam logic [3:0] ST_FRD  = 4'd6;
    localparam logic [3:0] ST_FMUL = 4'd7;
    localparam logic [3:0] ST_FACC = 4'd8;
    localparam logic [3:0] ST_FRES = 4'd9;
    localparam logic [3:0] ST_FSQ  = 4'd10;
    localparam logic [3:0] ST_FQ   = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    // Tables
    logic signed [31:0] mean_mem [FEATURES_MAX];
    logic signed [31:0] cent_mem [FEATURES_MAX];
    logic signed [31:0] rot_mem  [TD];
    logic signed [31:0] load_mem [TD];
    logic signed [31:0] mean_q;
    logic signed [31:0] cent_q;
    logic signed [31:0] rot_q;
    logic signed [31:0] load_q;

    logic [3:0]         state_reg;
    logic [NW-1:0]      cnt_reg;
    logic [CW-1:0]      c_reg;
    logic [FW-1:0]      fr_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] cen_reg;
    logic signed [31:0] r16_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] recon_reg;
    logic [62:0]        q_reg;
    logic               row_sat_reg;
    logic signed [63:0] acc_reg  [COMPONENTS_MAX];
    logic signed [31:0] sq16_reg [COMPONENTS_MAX];
    logic               res_valid_reg;
    result_t            res_data_reg;

    logic [NW-1:0]      nf;
    logic [CNW-1:0]     nc;
    logic [FW-1:0]      f_cur;
    logic [NW-1:0]      cnt_inc;
    logic               last_c;
    logic               last_f;
    logic [AW-1:0]      rot_addr;
    logic [AW-1:0]      load_addr;
    logic [AW-1:0]      wr_addr;
    logic [FW-1:0]      wr_feat;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_next;
    sat32_t             cen_s;
    sat64_t             acc_s;
    sat32_t             rnd_s;
    sat64_t             recon_s;
    sat64_t             res_s;
    sat32_t             r16_s;
    logic signed [63:0] neg_recon;
    logic [63:0]        q_sum;
    logic               out_free;
    logic               is_load;

    // Clamp the counts in use
    always_comb
    begin
        if (cfg_regs.feature_count < 9'd2)
        begin
            nf = NW'(2);
        end
        else if (int'(cfg_regs.feature_count) > FEATURES_MAX)
        begin
            nf = NW'(FEATURES_MAX);
        end
        else
        begin
            nf = NW'(cfg_regs.feature_count);
        end
        if (cfg_regs.component_count == 4'd0)
        begin
            nc = CNW'(1);
        end
        else if (int'(cfg_regs.component_count) > COMPONENTS_MAX)
        begin
            nc = CNW'(COMPONENTS_MAX);
        end
        else
        begin
            nc = CNW'(cfg_regs.component_count);
        end
    end

    assign f_cur   = (cnt_reg >= NW'(FEATURES_MAX)) ? FW'(FEATURES_MAX - 1)
                                                    : cnt_reg[FW-1:0];
    assign cnt_inc = NW'(f_cur) + NW'(1);
    assign last_c  = (CNW'(c_reg) + CNW'(1)) == nc;
    assign last_f  = (NW'(fr_reg) + NW'(1)) == nf;

    assign rot_addr  = AW'(f_cur) * AW'(COMPONENTS_MAX) + AW'(c_reg);
    assign load_addr = AW'(fr_reg) * AW'(COMPONENTS_MAX) + AW'(c_reg);
    assign wr_feat   = FW'(head.item.feature_index);
    assign wr_addr   = AW'(wr_feat) * AW'(COMPONENTS_MAX) +
                       AW'(head.item.component_index);

    assign pop      = (state_reg == ST_IDLE) && head.valid;
    assign is_load  = pop && (head.item.operation != OP_SAMPLE);
    assign out_free = !res_valid_reg || results.ready;

    // Table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (is_load && (head.item.operation == OP_LOAD_MEAN))
        begin
            mean_mem[wr_feat] <= head.item.value;
        end
        if (is_load && (head.item.operation == OP_LOAD_ROTATION))
        begin
            rot_mem[wr_addr] <= head.item.value;
        end
        if (is_load && (head.item.operation == OP_LOAD_LOADING))
        begin
            load_mem[wr_addr] <= head.item.value;
        end
        if (state_reg == ST_CEN)
        begin
            cent_mem[f_cur] <= cen_s.val;
        end
        mean_q <= mean_mem[f_cur];
        cent_q <= cent_mem[fr_reg];
        rot_q  <= rot_mem[rot_addr];
        load_q <= load_mem[load_addr];
    end

    // Select shared multiplier operands
    always_comb
    begin
        unique case (state_reg)
            ST_SMUL:
            begin
                mul_a = cen_reg;
                mul_b = rot_q;
            end
            ST_FMUL:
            begin
                mul_a = sq16_reg[c_reg];
                mul_b = load_q;
            end
            default:
            begin
                mul_a = r16_reg;
                mul_b = r16_reg;
            end
        endcase
    end

    assign prod_next = 64'(mul_a) * 64'(mul_b);

    // Arithmetic of each step
    assign cen_s     = sat32_from33(33'(val_reg) - 33'(mean_q));
    assign acc_s     = sat_add64(acc_reg[c_reg], prod_reg);
    assign rnd_s     = round_q16(acc_reg[c_reg]);
    assign recon_s   = sat_add64(recon_reg, prod_reg);
    assign neg_recon = (recon_reg == S64_MIN) ? S64_MAX : -recon_reg;
    assign res_s     = sat_add64({{16{cen_reg[31]}}, cen_reg, 16'h0000}, neg_recon);
    assign r16_s     = round_q16(res_s.sum);
    assign q_sum     = {1'b0, q_reg} + prod_reg;

    // Sequence the work of one transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            c_reg         <= '0;
            fr_reg        <= '0;
            row_sat_reg   <= 1'b0;
            q_reg         <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < COMPONENTS_MAX; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            prod_reg <= prod_next;
            // Drop the result once taken, unless a new one replaces it
            if (res_valid_reg && results.ready && !((state_reg == ST_OUT) && out_free))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop && (head.item.operation == OP_SAMPLE))
                    begin
                        val_reg   <= head.item.value;
                        state_reg <= ST_CEN;
                    end
                end
                ST_CEN:
                begin
                    cen_reg <= cen_s.val;
                    if (cen_s.sat)
                    begin
                        row_sat_reg <= 1'b1;
                    end
                    c_reg     <= '0;
                    state_reg <= ST_SRD;
                end
                ST_SRD:
                begin
                    state_reg <= ST_SMUL;
                end
                ST_SMUL:
                begin
                    state_reg <= ST_SACC;
                end
                ST_SACC:
                begin
                    acc_reg[c_reg] <= acc_s.sum;
                    if (acc_s.sat)
                    begin
                        row_sat_reg <= 1'b1;
                    end
                    if (last_c)
                    begin
                        c_reg   <= '0;
                        cnt_reg <= cnt_inc;
                        state_reg <= (cnt_inc >= nf) ? ST_RND : ST_IDLE;
                    end
                    else
                    begin
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= ST_SRD;
                    end
                end
                ST_RND:
                begin
                    sq16_reg[c_reg] <= rnd_s.val;
                    if (rnd_s.sat)
                    begin
                        row_sat_reg <= 1'b1;
                    end
                    if (last_c)
                    begin
                        c_reg     <= '0;
                        fr_reg    <= '0;
                        recon_reg <= '0;
                        state_reg <= ST_FRD;
                    end
                    else
                    begin
                        c_reg <= c_reg + CW'(1);
                    end
                end
                ST_FRD:
                begin
                    state_reg <= ST_FMUL;
                end
                ST_FMUL:
                begin
                    state_reg <= ST_FACC;
                end
                ST_FACC:
                begin
                    recon_reg <= recon_s.sum;
                    if (recon_s.sat)
                    begin
                        row_sat_reg <= 1'b1;
                    end
                    if (last_c)
                    begin
                        cen_reg   <= cent_q;
                        state_reg <= ST_FRES;
                    end
                    else
                    begin
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= ST_FRD;
                    end
                end
                ST_FRES:
                begin
                    r16_reg <= r16_s.val;
                    if (res_s.sat || r16_s.sat || (recon_reg == S64_MIN))
                    begin
                        row_sat_reg <= 1'b1;
                    end
                    state_reg <= ST_FSQ;
                end
                ST_FSQ:
                begin
                    state_reg <= ST_FQ;
                end
                ST_FQ:
                begin
                    if (q_sum > Q_MAX)
                    begin
                        q_reg       <= Q_MAX[62:0];
                        row_sat_reg <= 1'b1;
                    end
                    else
                    begin
                        q_reg <= q_sum[62:0];
                    end
                    c_reg     <= '0;
                    recon_reg <= '0;
                    if (last_f)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        fr_reg    <= fr_reg + FW'(1);
                        state_reg <= ST_FRD;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        cnt_reg       <= '0;
                        row_sat_reg   <= 1'b0;
                        q_reg         <= '0;
                        for (int i = 0; i < COMPONENTS_MAX; i++)
                        begin
                            acc_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            res_data_reg.q_value   <= q_reg;
            res_data_reg.saturated <= row_sat_reg;
        end
    end

    assign results.valid = res_valid_reg;
    assign results.data  = res_data_reg;

    // Pop only while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while busy");

    // Feature counter never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(FEATURES_MAX))
        else $error("feature counter out of range");

    // A new result comes only from the output step
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg)) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside output step");

    // Component counter stays below the count in use while scoring
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SACC) |-> (CNW'(c_reg) < nc))
        else $error("component counter out of range");

endmodule

FILE: hdl/pls_q_residual_statistic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_q_residual_statistic
// PLS Q (squared prediction error) statistic per sample row.
// ----------------------------------------------------------------------------
// Load transactions write the mean, rotation and loading tables without
// taking the back end out of idle; loads addressing beyond the tables are
// dropped. A sample is centered, then takes a registered table read, a
// multiply on the single shared multiplier and an accumulate per component
// (nc = components in use). The last sample of a row adds the score rounding,
// reconstruction and residual sum (nf = features in use). A two-entry queue
// lets input transactions be accepted while the back end works, and the
// result register holds a finished row while the next one starts. Write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
module pls_q_residual_statistic #(
    parameter int FEATURES_MAX   = 256,
    parameter int COMPONENTS_MAX = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    pqrs_item_if.sink     items,
    pqrs_result_if.source results,
    pqrs_cfg_if.sink      cfg
);
    import pqrs_pkg::*;

    cfg_regs_t   cfg_regs_reg;
    queue_head_t head;
    logic        pop;

    assign cfg.ready = 1'b1;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.feature_count   <= FEATURE_COUNT_RESET;
            cfg_regs_reg.component_count <= COMPONENT_COUNT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.data.index == REG_FEATURE_COUNT)
            begin
                cfg_regs_reg.feature_count <= cfg.data.value[8:0];
            end
            else if (cfg.data.index == REG_COMPONENT_COUNT)
            begin
                cfg_regs_reg.component_count <= cfg.data.value[3:0];
            end
        end
    end

    pqrs_front #(
        .FEATURES_MAX   (FEATURES_MAX),
        .COMPONENTS_MAX (COMPONENTS_MAX)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .items (items),
        .head  (head),
        .pop   (pop)
    );

    pqrs_back #(
        .FEATURES_MAX   (FEATURES_MAX),
        .COMPONENTS_MAX (COMPONENTS_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs_reg),
        .head     (head),
        .pop      (pop),
        .results  (results)
    );

endmodule

FILE: tb/tb_pls_q_residual_statistic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pls_q_residual_statistic
// Self-checking testbench of the PLS Q residual statistic block.
// ----------------------------------------------------------------------------
// A short directed table checks known rows: zero rows, extreme samples and
// centering saturation. It also checks a rebuilt feature that cancels
// exactly. Random phases follow, one per feature/component setting, with the
// extremes and out-of-range register values among them. Each phase first
// fills every table entry the setting reads that no earlier phase filled. It
// then mixes samples with random table reloads. Every accepted transaction
// runs through a local fixed-point model of the row statistic. Every result
// is compared with the oldest predicted row.
// ----------------------------------------------------------------------------
module tb_pls_q_residual_statistic;
    import pqrs_pkg::*;

    localparam int NF_MAX = 256;
    localparam int NC_MAX = 8;

    logic clk;
    logic rst_n;

    pqrs_item_if   items_ch ();
    pqrs_result_if rows_ch ();
    pqrs_cfg_if    cfg_ch ();

    pls_q_residual_statistic uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (rows_ch),
        .cfg     (cfg_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Local copy of the block state
    logic signed [31:0] mean_mem [NF_MAX];
    logic signed [31:0] rot_mem [NF_MAX*NC_MAX];
    logic signed [31:0] load_mem [NF_MAX*NC_MAX];
    logic signed [31:0] centered_mem [NF_MAX];
    longint             score_acc [NC_MAX];
    int                 row_pos;
    bit                 row_sat;
    int                 feature_reg;
    int                 component_reg;

    // Components already filled per feature (mean filled once nonzero)
    int                 filled_nc [NF_MAX];

    result_t expected_rows[$];
    int      mismatches;
    int      burst_left;

    function automatic int features_in_use();
        return (feature_reg < 2) ? 2 : (feature_reg > NF_MAX) ? NF_MAX : feature_reg;
    endfunction

    function automatic int components_in_use();
        return (component_reg < 1) ? 1 : (component_reg > NC_MAX) ? NC_MAX : component_reg;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            row_sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            row_sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            row_sat = 1'b1;
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    // Q32.32 to Q16.16, round half up
    function automatic logic signed [31:0] to_q16(longint v);
        longint k;
        k = v >>> 15;
        return clip32((k + 64'sd1) >>> 1);
    endfunction

    // Advance the model by one accepted transaction; queue a finished row
    task automatic model_item(item_t it);
        int                 nf;
        int                 nc;
        int                 f;
        logic signed [31:0] cen;
        logic signed [31:0] score16 [NC_MAX];
        logic signed [31:0] r16;
        longint             recon;
        longint             res;
        longint             sq;
        longint             q;
        result_t            row;
        nf = features_in_use();
        nc = components_in_use();
        case (it.operation)
            OP_LOAD_MEAN:     mean_mem[it.feature_index] = it.value;
            OP_LOAD_ROTATION: rot_mem[it.feature_index*NC_MAX + it.component_index] = it.value;
            OP_LOAD_LOADING:  load_mem[it.feature_index*NC_MAX + it.component_index] = it.value;
            default:
            begin
                f = (row_pos >= NF_MAX) ? NF_MAX - 1 : row_pos;
                cen = clip32(longint'(it.value) - longint'(mean_mem[f]));
                centered_mem[f] = cen;
                for (int c = 0; c < nc; c++)
                    score_acc[c] = add_sat(score_acc[c],
                                           longint'(cen) * longint'(rot_mem[f*NC_MAX + c]));
                row_pos = f + 1;
                if (row_pos >= nf)
                begin
                    q = 0;
                    for (int c = 0; c < nc; c++)
                        score16[c] = to_q16(score_acc[c]);
                    for (int g = 0; g < nf; g++)
                    begin
                        recon = 0;
                        for (int c = 0; c < nc; c++)
                            recon = add_sat(recon, longint'(score16[c]) *
                                                   longint'(load_mem[g*NC_MAX + c]));
                        if (recon == S64_MIN)
                        begin
                            row_sat = 1'b1;
                            res = add_sat(longint'(centered_mem[g]) * 65536, S64_MAX);
                        end
                        else
                            res = add_sat(longint'(centered_mem[g]) * 65536, -recon);
                        r16 = to_q16(res);
                        sq = longint'(r16) * longint'(r16);
                        if (q > S64_MAX - sq)
                        begin
                            q = S64_MAX;
                            row_sat = 1'b1;
                        end
                        else
                            q = q + sq;
                    end
                    row.q_value   = q[62:0];
                    row.saturated = row_sat;
                    expected_rows.push_back(row);
                    for (int c = 0; c < NC_MAX; c++)
                        score_acc[c] = 0;
                    row_pos = 0;
                    row_sat = 1'b0;
                end
            end
        endcase
    endtask

    // Send one transaction in bursts with random gaps
    task automatic send_item(item_t it);
        if (burst_left == 0)
        begin
            items_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 20);
        end
        items_ch.valid <= 1'b1;
        items_ch.data  <= it;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        burst_left--;
        model_item(it);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        cfg_write_t w;
        w.index = idx;
        w.value = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_FEATURE_COUNT)
            feature_reg = int'(val[8:0]);
        else if (idx == REG_COMPONENT_COUNT)
            component_reg = int'(val[3:0]);
    endtask

    // Small Q16.16 values half the time, with extremes and full-range noise
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic item_t make_item(logic [1:0] op, int fi, int ci, logic signed [31:0] v);
        item_t it;
        it.operation       = op;
        it.feature_index   = fi[7:0];
        it.component_index = ci[2:0];
        it.value           = v;
        return it;
    endfunction

    // Let the queue drain, then hold until loads in flight have retired
    task automatic drain();
        items_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Receiver stall pattern: free runs, coin flips and heavy stalls
    int stall_mode;
    int stall_left;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rows_ch.ready <= 1'b0;
            stall_mode    <= 0;
            stall_left    <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(5, 60);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0:       rows_ch.ready <= 1'b1;
                1:       rows_ch.ready <= 1'($urandom_range(0, 1));
                default: rows_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare every result transaction with the oldest predicted row
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rows_ch.valid && rows_ch.ready)
        begin
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected row q=%h sat=%b",
                             rows_ch.data.q_value, rows_ch.data.saturated);
            end
            else
            begin
                want = expected_rows.pop_front();
                if (rows_ch.data.q_value != want.q_value ||
                    rows_ch.data.saturated != want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: row q=%h sat=%b, expected q=%h sat=%b",
                                 rows_ch.data.q_value, rows_ch.data.saturated,
                                 want.q_value, want.saturated);
                end
            end
        end
    end

    typedef struct {
        logic [1:0]         op;
        int                 fi;
        int                 ci;
        logic signed [31:0] val;
        bit                 has_row;
        logic [62:0]        q;
        bit                 sat;
    } step_t;

    // Directed rows at reset setting: two features, one component
    step_t directed [] = '{
        '{OP_LOAD_MEAN,     0,   0, 32'sh0000_0000, 0, 63'h0, 0},
        '{OP_LOAD_MEAN,     1,   0, 32'sh0000_0000, 0, 63'h0, 0},
        '{OP_LOAD_ROTATION, 0,   0, 32'sh0000_0000, 0, 63'h0, 0},
        '{OP_LOAD_ROTATION, 1,   0, 32'sh0000_0000, 0, 63'h0, 0},
        '{OP_LOAD_LOADING,  0,   0, 32'sh0000_0000, 0, 63'h0, 0},
        '{OP_LOAD_LOADING,  1,   0, 32'sh0000_0000, 0, 63'h0, 0},
        '{OP_LOAD_ROTATION, 255, 7, 32'sh7FFF_FFFF, 0, 63'h0, 0},
        '{OP_LOAD_LOADING,  255, 7, 32'sh8000_0000, 0, 63'h0, 0},
        '{OP_LOAD_MEAN,     255, 7, 32'shFFFF_FFFF, 0, 63'h0, 0},
        '{OP_SAMPLE,        0,   0, 32'sh0000_0000, 0, 63'h0, 0},
        '{OP_SAMPLE,        0,   0, 32'sh0000_0000, 1, 63'h0, 0},
        '{OP_SAMPLE,        255, 7, 32'sh7FFF_FFFF, 0, 63'h0, 0},
        '{OP_SAMPLE,        0,   0, 32'sh0000_0000, 1, 63'h3FFF_FFFF_0000_0001, 0},
        '{OP_LOAD_MEAN,     0,   0, 32'sh7FFF_FFFF, 0, 63'h0, 0},
        '{OP_SAMPLE,        0,   0, 32'sh8000_0000, 0, 63'h0, 0},
        '{OP_SAMPLE,        0,   0, 32'sh0000_0000, 1, 63'h4000_0000_0000_0000, 1},
        '{OP_LOAD_MEAN,     0,   0, 32'sh0000_0000, 0, 63'h0, 0},
        '{OP_LOAD_ROTATION, 0,   0, 32'sh0001_0000, 0, 63'h0, 0},
        '{OP_LOAD_LOADING,  0,   0, 32'sh0001_0000, 0, 63'h0, 0},
        '{OP_SAMPLE,        0,   0, 32'sh0003_0000, 0, 63'h0, 0},
        '{OP_SAMPLE,        0,   0, 32'sh0001_0000, 1, 63'h1_0000_0000, 0},
        '{OP_SAMPLE,        0,   0, 32'shFFFF_0000, 0, 63'h0, 0},
        '{OP_SAMPLE,        0,   0, 32'sh8000_0000, 0, 63'h0, 0},
        '{OP_LOAD_ROTATION, 128, 5, 32'sh1234_5678, 0, 63'h0, 0}
    };

    // Random phases: feature and component register values, item count
    int phase_nf [5] = '{3, 0, 5, 511, 4};
    int phase_nc [5] = '{8, 0, 15, 1, 3};
    int phase_n  [5] = '{60, 40, 50, 40, 40};

    // Main sequence
    initial
    begin
        item_t it;
        int    nf;
        int    nc;
        rst_n          = 1'b0;
        items_ch.valid = 1'b0;
        items_ch.data  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        feature_reg    = int'(FEATURE_COUNT_RESET);
        component_reg  = int'(COMPONENT_COUNT_RESET);
        row_pos        = 0;
        row_sat        = 1'b0;
        mismatches     = 0;
        burst_left     = 0;
        for (int c = 0; c < NC_MAX; c++)
            score_acc[c] = 0;
        for (int f = 0; f < NF_MAX; f++)
            filled_nc[f] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed[i])
        begin
            send_item(make_item(directed[i].op, directed[i].fi, directed[i].ci,
                                directed[i].val));
            if (directed[i].has_row)
            begin
                expected_rows[expected_rows.size()-1].q_value   = directed[i].q;
                expected_rows[expected_rows.size()-1].saturated = directed[i].sat;
            end
        end
        // Close any open row
        while (row_pos != 0)
            send_item(make_item(OP_SAMPLE, 0, 0, pick_value()));
        drain();

        foreach (phase_n[p])
        begin
            write_reg(REG_FEATURE_COUNT, phase_nf[p]);
            write_reg(REG_COMPONENT_COUNT, phase_nc[p]);
            nf = features_in_use();
            nc = components_in_use();
            // Fill every entry this setting reads that is still empty
            for (int f = 0; f < nf; f++)
            begin
                if (filled_nc[f] == 0)
                    send_item(make_item(OP_LOAD_MEAN, f, $urandom_range(0, 7), pick_value()));
                for (int c = filled_nc[f]; c < nc; c++)
                begin
                    send_item(make_item(OP_LOAD_ROTATION, f, c, pick_value()));
                    send_item(make_item(OP_LOAD_LOADING, f, c, pick_value()));
                end
                if (filled_nc[f] < nc)
                    filled_nc[f] = nc;
            end
            // Samples mixed with table reloads
            for (int n = 0; n < phase_n[p]; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                    it = make_item(OP_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 7),
                                   pick_value());
                else
                    it = make_item(2'($urandom_range(0, 2)), $urandom_range(0, 255),
                                   $urandom_range(0, 7), pick_value());
                send_item(it);
            end
            while (row_pos != 0)
                send_item(make_item(OP_SAMPLE, $urandom_range(0, 255), 0, pick_value()));
            drain();
        end

        if (mismatches == 0 && expected_rows.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: pls_q_residual_statistic.f
hdl/pqrs_pkg.sv
hdl/pqrs_if.sv
hdl/pqrs_front.sv
hdl/pqrs_back.sv
hdl/pls_q_residual_statistic.sv
tb/tb_pls_q_residual_statistic.sv
